// File: sv/gve_pkg.sv
// Shared constants and types for the gated velocity estimator.
// Used by the core, its serial arithmetic units and the port checker.
// Depends on nothing.
`default_nettype none

package gve_pkg;

    // Field widths.
    localparam int POS_W   = 12;
    localparam int TIME_W  = 48;
    localparam int VEL_W   = 24;
    localparam int LIMIT_W = 20;

    // One second in microseconds, and the width that holds it.
    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

    // The serial divider handles a 32-bit dividend: position change times
    // one second, or the magnitude of the sum of the raw value and the history.
    localparam int DIV_NUM_W = 32;

    localparam int HISTORY_TAPS_DEF = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd10000;

    typedef logic signed [VEL_W-1:0] t_vel;

    localparam t_vel VEL_MAX = 24'sh7FFFFF;
    localparam t_vel VEL_MIN = 24'sh800000;

endpackage

`default_nettype wire

// File: sv/gve_sdiv.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Uses gve_pkg for its default widths.
`default_nettype none

module gve_sdiv #(
    parameter int NUM_W = gve_pkg::DIV_NUM_W,
    parameter int DEN_W = gve_pkg::TIME_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0] n_trial;
    logic [DEN_W:0] n_diff;
    logic           n_ge;

    // Bring down the next dividend bit and try the subtraction.
    assign n_trial = {r_rem, r_quo[NUM_W-1]};
    assign n_diff  = n_trial - {1'b0, r_den};
    assign n_ge    = (n_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W - 1);
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], n_ge};
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// File: sv/gve_smul.sv
// Shift-add serial multiplier, one multiplier bit per cycle, LSB first.
// Uses gve_pkg for its default widths.
`default_nettype none

module gve_smul #(
    parameter int A_W = gve_pkg::TIME_W,
    parameter int B_W = gve_pkg::LIMIT_W
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [A_W-1:0] i_a,
    input  wire logic [B_W-1:0] i_b,
    output logic                o_busy,
    output logic [A_W+B_W-1:0]  o_prod
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_acc;
    logic [B_W-1:0]   r_b;

    logic [A_W:0] n_sum;

    // The low product bits shift into the multiplier register as it drains.
    assign n_sum = {1'b0, r_acc} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(B_W - 1);
            r_a    <= i_a;
            r_acc  <= '0;
            r_b    <= i_b;
        end else if (r_busy) begin
            r_acc <= n_sum[A_W:1];
            r_b   <= {n_sum[0], r_b[B_W-1:1]};
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_acc, r_b};

endmodule

`default_nettype wire

// File: sv/gated_velocity_estimator_core.sv
// Gated velocity estimator: top level with sequencer, state and output register.
// Depends on gve_pkg, gve_sdiv and gve_smul.
`default_nettype none

//  Channel | Handshake           | Word
//  --------+---------------------+------------------------------------------
//  input   | i_valid / o_stall   | i_position_mm[11:0], i_time_us[47:0]
//  output  | o_valid / i_stall   | o_velocity[23:0] signed, o_rejected
//  config  | i_cfg_we            | i_cfg_data[19:0] (acceleration limit)
//
// A word with zero elapsed time goes from acceptance through the prepare step
// straight to the output register. A word rejected by the acceleration gate
// passes once through the shared serial divider, and an accepted word twice;
// each pass yields 32 quotient bits, one per cycle, after which the sequencer
// picks up the quotient.
// Reset is synchronous and active low; it restores the limit to 10000 and
// clears the reference position, time, velocity and raw history.
// A new word is taken while the previous result still waits in the output
// register; the sequencer only stalls at its last step if that register is full.

module gated_velocity_estimator_core #(
    parameter int HISTORY_TAPS = gve_pkg::HISTORY_TAPS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [gve_pkg::POS_W-1:0]       i_position_mm,
    input  wire logic [gve_pkg::TIME_W-1:0]      i_time_us,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [gve_pkg::VEL_W-1:0]     o_velocity,
    output logic                                 o_rejected,
    input  wire logic                            i_cfg_we,
    input  wire logic [gve_pkg::LIMIT_W-1:0]     i_cfg_data
);

    localparam int POS_W   = gve_pkg::POS_W;
    localparam int TIME_W  = gve_pkg::TIME_W;
    localparam int VEL_W   = gve_pkg::VEL_W;
    localparam int LIMIT_W = gve_pkg::LIMIT_W;
    localparam int US_W    = gve_pkg::US_W;
    localparam int NUM_W   = gve_pkg::DIV_NUM_W;

    // The sum of the raw value and the history needs room for TAPS+1 terms.
    localparam int SUM_W  = VEL_W + $clog2(HISTORY_TAPS + 1);
    localparam int PROD_W = TIME_W + LIMIT_W;
    localparam int LHS_W  = VEL_W + US_W;
    localparam int SCL_W  = POS_W + US_W;

    // Quotient thresholds for saturating the raw velocity.
    localparam logic [NUM_W-1:0] Q_NEG_LIM =
        {{(NUM_W - VEL_W){1'b0}}, 1'b1, {(VEL_W - 1){1'b0}}};
    localparam logic [NUM_W-1:0] Q_POS_LIM = Q_NEG_LIM - 1'b1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_GATE = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DIV2 = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;

    // Configuration and reference state.
    logic [LIMIT_W-1:0] r_limit;
    logic [TIME_W-1:0]  r_prev_time;
    logic [POS_W-1:0]   r_prev_pos;
    gve_pkg::t_vel      r_prev_vel;
    gve_pkg::t_vel      r_hist [HISTORY_TAPS];
    logic signed [SUM_W-1:0] r_hist_sum;

    // Working registers of the word in flight.
    logic [POS_W-1:0]   r_pos;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_dt;
    logic               r_diff_neg;
    gve_pkg::t_vel      r_raw;
    logic               r_rise_pos;
    logic [LHS_W-1:0]   r_lhs;
    logic signed [SUM_W-1:0] r_sum;
    gve_pkg::t_vel      r_res_vel;
    logic               r_res_rej;

    // Output register.
    logic               r_out_valid;
    gve_pkg::t_vel      r_out_vel;
    logic               r_out_rej;

    // Combinational next values.
    logic [TIME_W-1:0]  n_dt;
    logic               n_diff_neg;
    logic [POS_W-1:0]   n_diff_mag;
    logic [SCL_W-1:0]   n_scaled;
    gve_pkg::t_vel      n_raw;
    logic signed [VEL_W:0] n_rise;
    logic               n_rise_pos;
    logic [LHS_W-1:0]   n_lhs;
    logic signed [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0]   n_sum_mag;
    gve_pkg::t_vel      n_mean;
    logic               n_reject;
    logic signed [SUM_W-1:0] n_hist_sum;
    logic               n_out_free;

    // Shared arithmetic units.
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [TIME_W-1:0]  div_den;
    logic               div_busy;
    logic [NUM_W-1:0]   div_quot;
    logic               mul_start;
    logic               mul_busy;
    logic [PROD_W-1:0]  mul_prod;

    // Elapsed time wraps with the free-running timestamp.
    assign n_dt = i_time_us - r_prev_time;

    // Position change as sign and magnitude, scaled to mm/s numerator.
    assign n_diff_neg = (r_pos < r_prev_pos);
    assign n_diff_mag = n_diff_neg ? (r_prev_pos - r_pos) : (r_pos - r_prev_pos);
    assign n_scaled   = SCL_W'(n_diff_mag) * SCL_W'(gve_pkg::US_PER_S);

    // Raw velocity: apply the sign to the truncated quotient and saturate.
    always_comb begin
        if (r_diff_neg) begin
            if (div_quot >= Q_NEG_LIM) begin
                n_raw = gve_pkg::VEL_MIN;
            end else begin
                n_raw = -$signed(div_quot[VEL_W-1:0]);
            end
        end else begin
            if (div_quot > Q_POS_LIM) begin
                n_raw = gve_pkg::VEL_MAX;
            end else begin
                n_raw = $signed(div_quot[VEL_W-1:0]);
            end
        end
    end

    // The gate is one-sided: only a velocity rise is tested. It fails when
    // rise * 1e6 exceeds limit * dt; the latter comes from the serial
    // multiplier, which runs alongside the first division.
    assign n_rise     = {r_raw[VEL_W-1], r_raw} - {r_prev_vel[VEL_W-1], r_prev_vel};
    assign n_rise_pos = !n_rise[VEL_W] && (n_rise != '0);
    assign n_lhs      = LHS_W'(n_rise[VEL_W-1:0]) * LHS_W'(gve_pkg::US_PER_S);
    assign n_reject   = r_rise_pos && ({{(PROD_W - LHS_W){1'b0}}, r_lhs} > mul_prod);

    // Mean over the raw value and the history, truncated toward zero.
    assign n_sum     = {{(SUM_W - VEL_W){r_raw[VEL_W-1]}}, r_raw} + r_hist_sum;
    assign n_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign n_mean    = r_sum[SUM_W-1] ? -$signed(div_quot[VEL_W-1:0])
                                      : $signed(div_quot[VEL_W-1:0]);

    // Running history sum: drop the oldest entry, add the newest.
    assign n_hist_sum = r_hist_sum
                      - {{(SUM_W - VEL_W){r_hist[0][VEL_W-1]}}, r_hist[0]}
                      + {{(SUM_W - VEL_W){r_raw[VEL_W-1]}}, r_raw};

    // The divider serves the velocity quotient first, then the mean.
    assign div_start = ((r_state == S_PREP) && (r_dt != '0))
                    || ((r_state == S_CMP) && !n_reject);
    assign div_num   = (r_state == S_PREP) ? NUM_W'(n_scaled) : NUM_W'(n_sum_mag);
    assign div_den   = (r_state == S_PREP) ? r_dt : TIME_W'(HISTORY_TAPS + 1);
    assign mul_start = (r_state == S_PREP) && (r_dt != '0);

    gve_sdiv #(
        .NUM_W (NUM_W),
        .DEN_W (TIME_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    gve_smul #(
        .A_W (TIME_W),
        .B_W (LIMIT_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_dt),
        .i_b     (r_limit),
        .o_busy  (mul_busy),
        .o_prod  (mul_prod)
    );

    assign n_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= gve_pkg::LIMIT_RESET;
            r_prev_time <= '0;
            r_prev_pos  <= '0;
            r_prev_vel  <= '0;
            r_hist_sum  <= '0;
            for (int i = 0; i < HISTORY_TAPS; i++) begin
                r_hist[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end

            // In the last step the output register is reloaded instead.
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_pos   <= i_position_mm;
                        r_time  <= i_time_us;
                        r_dt    <= n_dt;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Zero elapsed time is held like a gate rejection.
                    if (r_dt == '0) begin
                        r_res_vel <= r_prev_vel;
                        r_res_rej <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_diff_neg <= n_diff_neg;
                        r_state    <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (!div_busy && !mul_busy) begin
                        r_raw   <= n_raw;
                        r_state <= S_GATE;
                    end
                end
                S_GATE: begin
                    r_rise_pos <= n_rise_pos;
                    r_lhs      <= n_lhs;
                    r_sum      <= n_sum;
                    r_state    <= S_CMP;
                end
                S_CMP: begin
                    if (n_reject) begin
                        r_res_vel <= r_prev_vel;
                        r_res_rej <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (!div_busy) begin
                        r_res_vel <= n_mean;
                        r_res_rej <= 1'b0;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_vel   <= r_res_vel;
                        r_out_rej   <= r_res_rej;
                        // Only an accepted word moves the reference point.
                        if (!r_res_rej) begin
                            r_prev_time <= r_time;
                            r_prev_pos  <= r_pos;
                            r_prev_vel  <= r_res_vel;
                            r_hist_sum  <= n_hist_sum;
                            for (int i = 0; i < HISTORY_TAPS - 1; i++) begin
                                r_hist[i] <= r_hist[i+1];
                            end
                            r_hist[HISTORY_TAPS-1] <= r_raw;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_velocity = r_out_vel;
    assign o_rejected = r_out_rej;

endmodule

`default_nettype wire

// File: sv/gve_chk.sv
// Port checker for the gated velocity estimator, attached by bind.
// Depends on gve_pkg and on the port list of gated_velocity_estimator_core.
`default_nettype none

module gve_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic [gve_pkg::POS_W-1:0]       i_position_mm,
    input wire logic [gve_pkg::TIME_W-1:0]      i_time_us,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic signed [gve_pkg::VEL_W-1:0] o_velocity,
    input wire logic                            o_rejected,
    input wire logic                            i_cfg_we,
    input wire logic [gve_pkg::LIMIT_W-1:0]     i_cfg_data
);

    logic          in_acc;
    logic          out_acc;
    gve_pkg::t_vel r_last_vel;
    logic [1:0]    r_pend;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Last delivered velocity, and words taken but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_vel <= '0;
            r_pend     <= '0;
        end else begin
            if (out_acc) begin
                r_last_vel <= o_velocity;
            end
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_velocity) && $stable(o_rejected))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("input taken while a word is still in work");

    a_held_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_velocity == r_last_vel)
        else $error("held word does not repeat the last velocity");

    a_no_extra_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 2'd0)
        else $error("output word without an input word");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

endmodule

bind gated_velocity_estimator_core gve_chk u_gve_chk (.*);

`default_nettype wire
